// File: hw/rtl/gpr_pkg.sv
// Shared types, constants and configuration codes of the Gaussian pyramid reduce unit.
`timescale 1ns / 1ps

package gpr_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int PIXEL_BITS = 16;

    localparam int FW_W       = 13;
    localparam int FH_W       = 16;
    localparam int CX_OUT_W   = 11;
    localparam int CY_W       = 15;
    localparam int CXS_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [FW_W-1:0] FINE_WIDTH_RESET  = 13'd640;
    localparam logic [FH_W-1:0] FINE_HEIGHT_RESET = 16'd480;

    localparam logic [CFG_IDX_W-1:0] CFG_FINE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FINE_HEIGHT = 2'd1;

    typedef struct packed {
        logic [FW_W-1:0] fine_width;
        logic [FH_W-1:0] fine_height;
    } t_cfg;

    typedef struct packed {
        logic             valid;
        logic [CXS_W-1:0] x0;
        logic [CXS_W-1:0] x1;
        logic [CY_W-1:0]  y0;
        logic [CY_W-1:0]  y1;
    } t_run;

endpackage

// File: hw/rtl/gpr_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module gpr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/gpr_column_stage.sv
// Raster counters, line store read-modify-write, vertical and horizontal filter sums.
`timescale 1ns / 1ps

module gpr_column_stage #(
    parameter int MAX_WIDTH  = gpr_pkg::MAX_WIDTH,
    parameter int PIXEL_BITS = gpr_pkg::PIXEL_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  gpr_pkg::t_cfg                i_cfg,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [PIXEL_BITS-1:0] i_pixel_value,
    output gpr_pkg::t_run                o_run,
    output logic signed [PIXEL_BITS-1:0] o_run_value,
    input  logic                         i_load_ok
);

    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int EWW  = $clog2(MAX_WIDTH + 1);
    localparam int CMPW = (EWW > gpr_pkg::FW_W) ? EWW : gpr_pkg::FW_W;
    localparam int WW   = 4 * PIXEL_BITS;
    localparam int CSW  = PIXEL_BITS + 4;
    localparam int HSW  = PIXEL_BITS + 8;

    logic [XW-1:0]           r_x;
    logic [15:0]             r_y;
    logic                    r_s1_vld;
    logic [XW-1:0]           r_s1_x;
    logic [15:0]             r_s1_y;
    logic [PIXEL_BITS-1:0]   r_s1_val;
    logic                    r_fw_vld;
    logic [XW-1:0]           r_fw_addr;
    logic [WW-1:0]           r_fw_word;
    logic signed [CSW-1:0]   r_cs [5];
    logic                    r_s2_vld;
    logic                    r_s2_emit;
    logic [gpr_pkg::CXS_W-1:0] r_s2_x0;
    logic [gpr_pkg::CXS_W-1:0] r_s2_x1;
    logic [gpr_pkg::CY_W-1:0]  r_s2_y0;
    logic [gpr_pkg::CY_W-1:0]  r_s2_y1;

    logic                    accept;
    logic                    s1_fire;
    logic                    s2_fire;
    logic [EWW-1:0]          ew;
    logic [15:0]             eh;
    logic [EWW-1:0]          cw;
    logic [15:0]             ch;
    logic [XW:0]             x_inc;
    logic [16:0]             y_inc;
    logic [XW-1:0]           n_x;
    logic [15:0]             n_y;
    logic [WW-1:0]           ram_rdata;
    logic [WW-1:0]           s1_word;
    logic [WW-1:0]           n_word;
    logic signed [CSW-1:0]   w [5];
    logic signed [CSW-1:0]   colsum;
    logic [XW-2:0]           ci;
    logic [XW-1:0]           xh1;
    logic [14:0]             cj;
    logic [15:0]             yh1;
    logic                    s1_emit;
    logic [gpr_pkg::CXS_W-1:0] s1_x0;
    logic [gpr_pkg::CXS_W-1:0] s1_x1;
    logic [gpr_pkg::CY_W-1:0]  s1_y0;
    logic [gpr_pkg::CY_W-1:0]  s1_y1;
    logic signed [HSW-1:0]   hs;
    logic signed [HSW-1:0]   hs_rnd;

    always_comb begin
        if (CMPW'(i_cfg.fine_width) > CMPW'(MAX_WIDTH)) begin
            ew = EWW'(MAX_WIDTH);
        end else if (i_cfg.fine_width == '0) begin
            ew = EWW'(1);
        end else begin
            ew = EWW'(i_cfg.fine_width);
        end
        eh = (i_cfg.fine_height == '0) ? 16'd1 : i_cfg.fine_height;
    end

    assign cw = EWW'(({1'b0, ew} + (EWW + 1)'(1)) >> 1);
    assign ch = 16'(({1'b0, eh} + 17'd1) >> 1);

    assign s2_fire = r_s2_vld && (!r_s2_emit || i_load_ok);
    assign s1_fire = r_s1_vld && (!r_s2_vld || s2_fire);
    assign o_ready = !r_s1_vld || s1_fire;
    assign accept  = i_valid && o_ready;

    always_comb begin
        x_inc = {1'b0, r_x} + (XW + 1)'(1);
        y_inc = {1'b0, r_y} + 17'd1;
        n_x   = x_inc[XW-1:0];
        n_y   = r_y;
        if (x_inc >= (XW + 1)'(ew)) begin
            n_x = '0;
            n_y = (y_inc >= {1'b0, eh}) ? 16'd0 : y_inc[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x      <= '0;
            r_y      <= '0;
            r_s1_vld <= 1'b0;
            r_fw_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_x <= n_x;
                r_y <= n_y;
            end
            if (accept) begin
                r_s1_vld <= 1'b1;
            end else if (s1_fire) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_fire) begin
                r_fw_vld <= 1'b1;
            end
            if (s1_fire) begin
                r_s2_vld <= 1'b1;
            end else if (s2_fire) begin
                r_s2_vld <= 1'b0;
            end
        end
    end

    gpr_ram #(
        .WIDTH (WW),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (s1_fire),
        .i_waddr (r_s1_x),
        .i_wdata (n_word),
        .i_re    (accept),
        .i_raddr (r_x),
        .o_rdata (ram_rdata)
    );

    assign s1_word = (r_fw_vld && (r_fw_addr == r_s1_x)) ? r_fw_word : ram_rdata;

    always_comb begin
        logic [1:0] idx;
        n_word = s1_word;
        n_word[r_s1_y[1:0] * PIXEL_BITS +: PIXEL_BITS] = r_s1_val;
        for (int r = 0; r < 4; r++) begin
            idx  = r_s1_y[1:0] + 2'(r);
            w[r] = CSW'($signed(s1_word[idx * PIXEL_BITS +: PIXEL_BITS]));
        end
        w[4] = CSW'($signed(r_s1_val));
    end

    assign colsum = w[0] + (w[1] <<< 2) + (w[2] <<< 2) + (w[2] <<< 1) + (w[3] <<< 2) + w[4];

    always_comb begin
        ci  = r_s1_x[XW-1:1] - (XW - 1)'(1);
        xh1 = {1'b0, r_s1_x[XW-1:1]} + XW'(1);
        cj  = r_s1_y[15:1] - 15'd1;
        yh1 = {1'b0, r_s1_y[15:1]} + 16'd1;
        s1_emit = (ew >= EWW'(5)) && (eh >= 16'd5)
               && (r_s1_x >= XW'(4)) && (r_s1_y >= 16'd4)
               && !r_s1_x[0] && !r_s1_y[0]
               && (EWW'(xh1) <= cw) && (yh1 <= ch);
        s1_x0 = (r_s1_x == XW'(4)) ? '0 : gpr_pkg::CXS_W'(ci);
        s1_x1 = gpr_pkg::CXS_W'(ci) + gpr_pkg::CXS_W'(EWW'(xh1) == cw);
        s1_y0 = (r_s1_y == 16'd4) ? '0 : cj;
        s1_y1 = cj + gpr_pkg::CY_W'(yh1 == ch);
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_x   <= r_x;
            r_s1_y   <= r_y;
            r_s1_val <= i_pixel_value;
        end
        if (s1_fire) begin
            r_fw_addr <= r_s1_x;
            r_fw_word <= n_word;
            for (int k = 0; k < 4; k++) begin
                r_cs[k] <= r_cs[k+1];
            end
            r_cs[4]   <= colsum;
            r_s2_emit <= s1_emit;
            r_s2_x0   <= s1_x0;
            r_s2_x1   <= s1_x1;
            r_s2_y0   <= s1_y0;
            r_s2_y1   <= s1_y1;
        end
    end

    assign hs = HSW'(r_cs[0]) + (HSW'(r_cs[1]) <<< 2) + (HSW'(r_cs[2]) <<< 2)
              + (HSW'(r_cs[2]) <<< 1) + (HSW'(r_cs[3]) <<< 2) + HSW'(r_cs[4]);
    assign hs_rnd = hs + $signed(HSW'(128));
    assign o_run_value = hs_rnd[PIXEL_BITS+7:8];

    assign o_run.valid = r_s2_vld && r_s2_emit;
    assign o_run.x0    = r_s2_x0;
    assign o_run.x1    = r_s2_x1;
    assign o_run.y0    = r_s2_y0;
    assign o_run.y1    = r_s2_y1;

endmodule

// File: hw/rtl/gpr_emitter.sv
// Output register that walks one run of coarse pixels in coarse raster order.
`timescale 1ns / 1ps

module gpr_emitter #(
    parameter int PIXEL_BITS = gpr_pkg::PIXEL_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  gpr_pkg::t_run                   i_run,
    input  logic signed [PIXEL_BITS-1:0]    i_run_value,
    output logic                            o_load_ok,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic signed [PIXEL_BITS-1:0]    o_coarse_value,
    output logic [gpr_pkg::CX_OUT_W-1:0]    o_coarse_x,
    output logic [gpr_pkg::CY_W-1:0]        o_coarse_y,
    output logic                            o_run_last
);

    logic                        r_vld;
    logic                        r_last;
    logic [PIXEL_BITS-1:0]       r_value;
    logic [gpr_pkg::CXS_W-1:0]   r_cx;
    logic [gpr_pkg::CXS_W-1:0]   r_x0;
    logic [gpr_pkg::CXS_W-1:0]   r_x1;
    logic [gpr_pkg::CY_W-1:0]    r_cy;
    logic [gpr_pkg::CY_W-1:0]    r_y1;

    logic                        load;
    logic                        step;
    logic [gpr_pkg::CXS_W-1:0]   n_cx;
    logic [gpr_pkg::CY_W-1:0]    n_cy;

    assign o_load_ok = !r_vld || (i_ready && r_last);
    assign load      = i_run.valid && o_load_ok;
    assign step      = r_vld && i_ready && !r_last;

    always_comb begin
        if (r_cx == r_x1) begin
            n_cx = r_x0;
            n_cy = r_cy + gpr_pkg::CY_W'(1);
        end else begin
            n_cx = r_cx + gpr_pkg::CXS_W'(1);
            n_cy = r_cy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (load) begin
            r_vld <= 1'b1;
        end else if (r_vld && i_ready && r_last) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_value <= i_run_value;
            r_cx    <= i_run.x0;
            r_cy    <= i_run.y0;
            r_x0    <= i_run.x0;
            r_x1    <= i_run.x1;
            r_y1    <= i_run.y1;
            r_last  <= (i_run.x0 == i_run.x1) && (i_run.y0 == i_run.y1);
        end else if (step) begin
            r_cx   <= n_cx;
            r_cy   <= n_cy;
            r_last <= (n_cx == r_x1) && (n_cy == r_y1);
        end
    end

    assign o_valid        = r_vld;
    assign o_coarse_value = r_value;
    assign o_coarse_x     = r_cx[gpr_pkg::CX_OUT_W-1:0];
    assign o_coarse_y     = r_cy;
    assign o_run_last     = r_last;

endmodule

// File: hw/rtl/gaussian_pyramid_reduce_unit.sv
// Top level of the Gaussian pyramid reduce unit: configuration registers and datapath.
//
// Fine pixels enter on the i_valid / o_ready channel in raster order, one
// transaction per pixel. Coarse pixels leave on the o_valid / i_ready channel
// with their coarse column and row; o_run_last marks the last coarse pixel
// caused by one fine pixel. A run holds one to nine coarse pixels, because the
// coarse border and corners are copies of the nearest interior pixel.
// The sizes fine_width and fine_height are written through the i_cfg_valid /
// o_cfg_ready channel, which always accepts, and must only change while idle.
// One fine pixel is accepted every cycle while the receiver keeps up and the
// output register is not busy with an earlier run. The accepting edge
// registers the line store read, the next stage the write-back and vertical
// sum, and the emitter then loads the horizontal sum into the output register,
// where the run's first coarse pixel is valid. A run holds the output register
// until its last result is taken; the stages behind it keep accepting until full.
// The line store holds one word of four rows per column, so each pixel costs
// one read and one write of the same memory port pair.
// Reset sets the sizes to 640 by 480 and the raster position to the origin;
// the line store is not cleared. When the receiver stalls, the output
// transaction holds and the pipeline fills, then o_ready drops.
`timescale 1ns / 1ps

module gaussian_pyramid_reduce_unit #(
    parameter int MAX_WIDTH  = gpr_pkg::MAX_WIDTH,
    parameter int PIXEL_BITS = gpr_pkg::PIXEL_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [gpr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [gpr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [PIXEL_BITS-1:0]      i_pixel_value,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [PIXEL_BITS-1:0]      o_coarse_value,
    output logic [gpr_pkg::CX_OUT_W-1:0]      o_coarse_x,
    output logic [gpr_pkg::CY_W-1:0]          o_coarse_y,
    output logic                              o_run_last
);

    gpr_pkg::t_cfg               r_cfg;
    gpr_pkg::t_run               run;
    logic signed [PIXEL_BITS-1:0] run_value;
    logic                        load_ok;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fine_width  <= gpr_pkg::FINE_WIDTH_RESET;
            r_cfg.fine_height <= gpr_pkg::FINE_HEIGHT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                gpr_pkg::CFG_FINE_WIDTH: begin
                    r_cfg.fine_width <= i_cfg_data[gpr_pkg::FW_W-1:0];
                end
                gpr_pkg::CFG_FINE_HEIGHT: begin
                    r_cfg.fine_height <= i_cfg_data[gpr_pkg::FH_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    gpr_column_stage #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_column_stage (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_pixel_value (i_pixel_value),
        .o_run         (run),
        .o_run_value   (run_value),
        .i_load_ok     (load_ok)
    );

    gpr_emitter #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_emitter (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_run          (run),
        .i_run_value    (run_value),
        .o_load_ok      (load_ok),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_coarse_value (o_coarse_value),
        .o_coarse_x     (o_coarse_x),
        .o_coarse_y     (o_coarse_y),
        .o_run_last     (o_run_last)
    );

endmodule

// File: sim/tb.sv
// Self-checking testbench for the Gaussian pyramid reduce unit with its own bit-exact predictor.
`timescale 1ns / 1ps

module tb;

    localparam int PIXEL_BITS   = gpr_pkg::PIXEL_BITS;
    localparam int MAX_WIDTH    = gpr_pkg::MAX_WIDTH;
    localparam int CX_OUT_W     = gpr_pkg::CX_OUT_W;
    localparam int CY_W         = gpr_pkg::CY_W;
    localparam int CFG_IDX_W    = gpr_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W   = gpr_pkg::CFG_DATA_W;
    localparam int FW_W         = gpr_pkg::FW_W;
    localparam int FH_W         = gpr_pkg::FH_W;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int DRAIN_CYCLES = 16;

    typedef enum int {PACE_FREE, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} t_pace;

    typedef struct {
        logic signed [PIXEL_BITS-1:0] value;
        logic [CX_OUT_W-1:0]          cx;
        logic [CY_W-1:0]              cy;
        logic                         last;
    } t_coarse;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_cfg_valid = 1'b0;
    logic                         o_cfg_ready;
    logic [CFG_IDX_W-1:0]         i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]        i_cfg_data = '0;
    logic                         i_valid = 1'b0;
    logic                         o_ready;
    logic signed [PIXEL_BITS-1:0] i_pixel_value = '0;
    logic                         o_valid;
    logic                         i_ready = 1'b0;
    logic signed [PIXEL_BITS-1:0] o_coarse_value;
    logic [CX_OUT_W-1:0]          o_coarse_x;
    logic [CY_W-1:0]              o_coarse_y;
    logic                         o_run_last;

    gaussian_pyramid_reduce_unit uut (.*);

    always #5 i_clk = ~i_clk;

    logic signed [PIXEL_BITS-1:0] pixel_q[$];
    t_coarse                      pending_coarse[$];
    t_coarse                      want;

    logic signed [PIXEL_BITS-1:0] line_rows [0:4*MAX_WIDTH-1];
    logic signed [PIXEL_BITS-1:0] win [5][5];
    int                           binom [5];
    int unsigned                  col_pos;
    int unsigned                  row_pos;
    logic [FW_W-1:0]              fine_w;
    logic [FH_W-1:0]              fine_h;

    logic pix_fire = 1'b0;
    logic cfg_fire = 1'b0;
    logic hold_off = 1'b0;
    int   send_idle = 0;
    int   recv_stall = 0;
    int   mismatches = 0;
    int   cycle_count = 0;

    function automatic int unsigned active_width();
        int unsigned w;
        w = fine_w;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        if (w == 0) w = 1;
        return w;
    endfunction

    function automatic int unsigned active_height();
        int unsigned h;
        h = fine_h;
        if (h == 0) h = 1;
        return h;
    endfunction

    function automatic void reduce_pixel(input logic signed [PIXEL_BITS-1:0] pix);
        int unsigned ew, eh, x, y, col, cw, ch, ci, cj;
        int unsigned ys[3], xs[3];
        int nr, nc, total, n;
        longint acc;
        logic signed [PIXEL_BITS-1:0] avg;
        t_coarse c;
        ew = active_width();
        eh = active_height();
        x = col_pos;
        y = row_pos;
        col = (x < MAX_WIDTH) ? x : MAX_WIDTH - 1;
        for (int r = 0; r < 5; r++)
            for (int k = 0; k < 4; k++)
                win[r][k] = win[r][k+1];
        for (int r = 0; r < 4; r++)
            win[r][4] = line_rows[((y + r) & 3) * MAX_WIDTH + col];
        win[4][4] = pix;
        line_rows[(y & 3) * MAX_WIDTH + col] = pix;
        cw = (ew - 1) / 2 + 1;
        ch = (eh - 1) / 2 + 1;
        if (ew >= 5 && eh >= 5 && x >= 4 && y >= 4 && x % 2 == 0 && y % 2 == 0) begin
            ci = (x - 2) / 2;
            cj = (y - 2) / 2;
            if (ci <= cw - 2 && cj <= ch - 2) begin
                acc = 0;
                for (int r = 0; r < 5; r++)
                    for (int k = 0; k < 5; k++)
                        acc += longint'(win[r][k]) * binom[r] * binom[k];
                avg = PIXEL_BITS'((acc + 128) >>> 8);
                nr = 0;
                nc = 0;
                if (cj == 1) begin
                    ys[nr] = 0;
                    nr++;
                end
                ys[nr] = cj;
                nr++;
                if (cj == ch - 2) begin
                    ys[nr] = ch - 1;
                    nr++;
                end
                if (ci == 1) begin
                    xs[nc] = 0;
                    nc++;
                end
                xs[nc] = ci;
                nc++;
                if (ci == cw - 2) begin
                    xs[nc] = cw - 1;
                    nc++;
                end
                total = nr * nc;
                n = 0;
                for (int a = 0; a < nr; a++)
                    for (int b = 0; b < nc; b++) begin
                        c.value = avg;
                        c.cx = CX_OUT_W'(xs[b]);
                        c.cy = CY_W'(ys[a]);
                        c.last = (n == total - 1);
                        pending_coarse.push_back(c);
                        n++;
                    end
            end
        end
        if (x + 1 >= ew) begin
            col_pos = 0;
            row_pos = (y + 1 >= eh) ? 0 : y + 1;
        end else begin
            col_pos = x + 1;
        end
    endfunction

    function automatic logic signed [PIXEL_BITS-1:0] rand_pixel();
        case ($urandom_range(15))
            0: return {1'b1, {(PIXEL_BITS-1){1'b0}}};
            1: return {1'b0, {(PIXEL_BITS-1){1'b1}}};
            default: return PIXEL_BITS'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < 200)
            $display("MISMATCH cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    task automatic set_pace(input t_pace pace);
        @(posedge i_clk);
        case (pace)
            PACE_FREE: begin
                send_idle = 0;
                recv_stall = 0;
            end
            PACE_SEND_IDLE: begin
                send_idle = 59;
                recv_stall = 0;
            end
            PACE_RECV_STALL: begin
                send_idle = 0;
                recv_stall = 59;
            end
            default: begin
                send_idle = 13;
                recv_stall = 13;
            end
        endcase
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(negedge i_clk); while (!cfg_fire);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic push_pixels(input int n);
        @(posedge i_clk);
        repeat (n) pixel_q.push_back(rand_pixel());
    endtask

    // Pushes just enough pixels to bring the raster position back to the origin.
    task automatic fill_frame();
        int unsigned x, y, ew, eh;
        int n;
        x = col_pos;
        y = row_pos;
        ew = active_width();
        eh = active_height();
        n = 0;
        do begin
            n++;
            if (x + 1 >= ew) begin
                x = 0;
                y = (y + 1 >= eh) ? 0 : y + 1;
            end else begin
                x = x + 1;
            end
        end while (x != 0 || y != 0);
        push_pixels(n);
    endtask

    task automatic settle();
        do @(posedge i_clk); while (pixel_q.size() != 0 || i_valid);
        while (pending_coarse.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_ready <= 1'b0;
        end else begin
            if (!i_valid || pix_fire) begin
                if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle) begin
                    i_valid <= 1'b1;
                    i_pixel_value <= pixel_q.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_ready <= !hold_off && ($urandom_range(99) >= recv_stall);
        end
    end

    always @(posedge i_clk) begin
        pix_fire <= i_rst_n && i_valid && o_ready;
        cfg_fire <= i_rst_n && i_cfg_valid && o_cfg_ready;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (pending_coarse.size() == 0) begin
                    report_mismatch($sformatf("unexpected coarse pixel at (%0d,%0d)",
                                              o_coarse_x, o_coarse_y));
                end else begin
                    want = pending_coarse.pop_front();
                    if (o_coarse_value !== want.value)
                        report_mismatch($sformatf("coarse (%0d,%0d) value %0d, expected %0d",
                                                  want.cx, want.cy, o_coarse_value, want.value));
                    if (o_coarse_x !== want.cx)
                        report_mismatch($sformatf("coarse x %0d, expected %0d",
                                                  o_coarse_x, want.cx));
                    if (o_coarse_y !== want.cy)
                        report_mismatch($sformatf("coarse y %0d, expected %0d",
                                                  o_coarse_y, want.cy));
                    if (o_run_last !== want.last)
                        report_mismatch($sformatf("coarse (%0d,%0d) run_last %b, expected %b",
                                                  want.cx, want.cy, o_run_last, want.last));
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    gpr_pkg::CFG_FINE_WIDTH:  fine_w = i_cfg_data[FW_W-1:0];
                    gpr_pkg::CFG_FINE_HEIGHT: fine_h = i_cfg_data[FH_W-1:0];
                    default: ;
                endcase
            end
            if (i_valid && o_ready)
                reduce_pixel(i_pixel_value);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("gaussian_pyramid_reduce_unit test failed");
            $finish;
        end
    end

    initial begin
        logic signed [PIXEL_BITS-1:0] opening [6];
        binom = '{1, 4, 6, 4, 1};
        for (int i = 0; i < 4 * MAX_WIDTH; i++)
            line_rows[i] = '0;
        for (int r = 0; r < 5; r++)
            for (int k = 0; k < 5; k++)
                win[r][k] = '0;
        col_pos = 0;
        row_pos = 0;
        fine_w = gpr_pkg::FINE_WIDTH_RESET;
        fine_h = gpr_pkg::FINE_HEIGHT_RESET;
        opening = '{16'sh8000, 16'sh7FFF, 16'sh0000, -16'sd1, 16'sd1, 16'sh5555};
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // A few pixels at the reset size, then a width change that wraps the column.
        set_pace(PACE_FREE);
        foreach (opening[i])
            pixel_q.push_back(opening[i]);
        settle();
        write_reg(gpr_pkg::CFG_FINE_WIDTH, 16'd5);
        write_reg(gpr_pkg::CFG_FINE_HEIGHT, 16'd5);
        @(posedge i_clk);
        pixel_q.push_back(16'shAAAA);
        repeat (20) pixel_q.push_back(16'sh7FFF);
        settle();

        // Zero and small sizes produce no output.
        set_pace(PACE_BOTH);
        write_reg(gpr_pkg::CFG_FINE_WIDTH, 16'd0);
        write_reg(gpr_pkg::CFG_FINE_HEIGHT, 16'd0);
        push_pixels(4);
        settle();
        write_reg(gpr_pkg::CFG_FINE_WIDTH, 16'd4);
        write_reg(gpr_pkg::CFG_FINE_HEIGHT, 16'd5);
        fill_frame();
        settle();
        write_reg(gpr_pkg::CFG_FINE_WIDTH, 16'd5);
        write_reg(gpr_pkg::CFG_FINE_HEIGHT, 16'd4);
        fill_frame();
        settle();

        // Tallest frame, cut short by a height change while the row count is past it.
        set_pace(PACE_SEND_IDLE);
        write_reg(gpr_pkg::CFG_FINE_WIDTH, 16'd5);
        write_reg(gpr_pkg::CFG_FINE_HEIGHT, 16'hFFFF);
        push_pixels(35);
        settle();
        write_reg(gpr_pkg::CFG_FINE_HEIGHT, 16'd6);
        fill_frame();
        settle();

        write_reg(gpr_pkg::CFG_FINE_WIDTH, 16'd7);
        write_reg(gpr_pkg::CFG_FINE_HEIGHT, 16'd5);
        push_pixels(14);
        settle();
        write_reg(gpr_pkg::CFG_FINE_HEIGHT, 16'd6);
        fill_frame();
        settle();

        set_pace(PACE_RECV_STALL);
        write_reg(gpr_pkg::CFG_FINE_WIDTH, 16'd8);
        write_reg(gpr_pkg::CFG_FINE_HEIGHT, 16'd5);
        push_pixels(38);
        settle();
        write_reg(gpr_pkg::CFG_FINE_WIDTH, 16'd6);
        fill_frame();
        settle();

        // A width beyond the line store, narrowed early in the first row.
        set_pace(PACE_FREE);
        write_reg(gpr_pkg::CFG_FINE_WIDTH, 16'hFFFF);
        write_reg(gpr_pkg::CFG_FINE_HEIGHT, 16'd7);
        push_pixels(3);
        settle();

        // The receiver holds off long enough for the input side to back up.
        write_reg(gpr_pkg::CFG_FINE_WIDTH, 16'd7);
        fork
            begin
                @(posedge i_clk);
                hold_off = 1'b1;
                repeat (400) @(posedge i_clk);
                hold_off = 1'b0;
            end
        join_none
        fill_frame();
        settle();

        if (mismatches == 0)
            $display("gaussian_pyramid_reduce_unit test passed");
        else
            $display("gaussian_pyramid_reduce_unit test failed");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/gpr_pkg.sv
hw/rtl/gpr_ram.sv
hw/rtl/gpr_column_stage.sv
hw/rtl/gpr_emitter.sv
hw/rtl/gaussian_pyramid_reduce_unit.sv
sim/tb.sv
